// ===== hw/rtl/xopd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xopd_pkg
// types and group codes shared by the 8086 primary opcode group decoder
// ----------------------------------------------------------------------------
package xopd_pkg;

    localparam int GroupWidth = 7;

    // handler groups, numbered in order of first appearance in the handler switch
    typedef enum logic [GroupWidth-1:0] {
        GRP_ADD      = 7'd0,
        GRP_PUSH     = 7'd1,
        GRP_POP      = 7'd2,
        GRP_OR       = 7'd3,
        GRP_ADC      = 7'd4,
        GRP_SBB      = 7'd5,
        GRP_AND      = 7'd6,
        GRP_SEG      = 7'd7,
        GRP_DAA      = 7'd8,
        GRP_SUB      = 7'd9,
        GRP_DAS      = 7'd10,
        GRP_XOR      = 7'd11,
        GRP_AAA      = 7'd12,
        GRP_CMP      = 7'd13,
        GRP_AAS      = 7'd14,
        GRP_INC      = 7'd15,
        GRP_DEC      = 7'd16,
        GRP_JUMP     = 7'd17,
        GRP_IMM80    = 7'd18,
        GRP_IMM81    = 7'd19,
        GRP_IMM82    = 7'd20,
        GRP_TEST     = 7'd21,
        GRP_XCHG     = 7'd22,
        GRP_NOP      = 7'd23,
        GRP_MOV      = 7'd24,
        GRP_LEA      = 7'd25,
        GRP_CBW      = 7'd26,
        GRP_CWD      = 7'd27,
        GRP_CALL     = 7'd28,
        GRP_WAIT     = 7'd29,
        GRP_SAHF     = 7'd30,
        GRP_LAHF     = 7'd31,
        GRP_MOVS     = 7'd32,
        GRP_CMPS     = 7'd33,
        GRP_STOS     = 7'd34,
        GRP_LODS     = 7'd35,
        GRP_SCAS     = 7'd36,
        GRP_RET      = 7'd37,
        GRP_LES      = 7'd38,
        GRP_LDS      = 7'd39,
        GRP_INT      = 7'd40,
        GRP_INTO     = 7'd41,
        GRP_IRET     = 7'd42,
        GRP_SHIFT_D0 = 7'd43,
        GRP_SHIFT_D1 = 7'd44,
        GRP_SHIFT_D2 = 7'd45,
        GRP_SHIFT_D3 = 7'd46,
        GRP_AAM      = 7'd47,
        GRP_AAD      = 7'd48,
        GRP_XLAT     = 7'd49,
        GRP_ESC      = 7'd50,
        GRP_LOOPNE   = 7'd51,
        GRP_LOOPE    = 7'd52,
        GRP_LOOP     = 7'd53,
        GRP_JCXZ     = 7'd54,
        GRP_IN       = 7'd55,
        GRP_OUT      = 7'd56,
        GRP_LOCK     = 7'd57,
        GRP_REPNE    = 7'd58,
        GRP_REP      = 7'd59,
        GRP_HLT      = 7'd60,
        GRP_CMC      = 7'd61,
        GRP_UNARY_F6 = 7'd62,
        GRP_UNARY_F7 = 7'd63,
        GRP_CLC      = 7'd64,
        GRP_STC      = 7'd65,
        GRP_CLI      = 7'd66,
        GRP_STI      = 7'd67,
        GRP_CLD      = 7'd68,
        GRP_STD      = 7'd69,
        GRP_MISC_FE  = 7'd70,
        GRP_MISC_FF  = 7'd71
    } group_t;

    // instruction word: opcode byte and the byte after it
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } insn_word_t;

    // decoded word
    typedef struct packed {
        logic                  valid_res;
        logic [GroupWidth-1:0] group;
        logic                  dir_bit;
        logic                  word_bit;
        logic [1:0]            mod_field;
        logic [2:0]            reg_field;
        logic [2:0]            rm_field;
    } decode_word_t;

    // classifier status toward the top level
    typedef struct packed {
        logic   known;
        group_t group;
    } class_t;

endpackage
`default_nettype wire

// ===== hw/rtl/xopd_insn_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xopd_insn_if
// valid/ready channel carrying one instruction word
// ----------------------------------------------------------------------------
interface xopd_insn_if;
    logic                    valid;
    logic                    ready;
    xopd_pkg::insn_word_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xopd_decode_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xopd_decode_if
// valid/ready channel carrying one decoded word
// ----------------------------------------------------------------------------
interface xopd_decode_if;
    logic                    valid;
    logic                    ready;
    xopd_pkg::decode_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xopd_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xopd_classify
// sorts a primary opcode byte into its handler group
// ----------------------------------------------------------------------------
module xopd_classify (
    input  wire logic [7:0]       opcode,
    output xopd_pkg::class_t      cls
);

    always_comb
    begin
        cls.known = 1'b1;
        unique case (opcode) inside
            [8'h00:8'h05]:                              cls.group = xopd_pkg::GRP_ADD;
            8'h06, 8'h0E, 8'h16, 8'h1E, [8'h50:8'h57],
            8'h9C:                                      cls.group = xopd_pkg::GRP_PUSH;
            // pop covers the whole register row, di included
            8'h07, 8'h17, 8'h1F, [8'h58:8'h5F], 8'h8F,
            8'h9D:                                      cls.group = xopd_pkg::GRP_POP;
            [8'h08:8'h0D]:                              cls.group = xopd_pkg::GRP_OR;
            [8'h10:8'h15]:                              cls.group = xopd_pkg::GRP_ADC;
            [8'h18:8'h1D]:                              cls.group = xopd_pkg::GRP_SBB;
            [8'h20:8'h25]:                              cls.group = xopd_pkg::GRP_AND;
            8'h26, 8'h2E, 8'h36, 8'h3E:                 cls.group = xopd_pkg::GRP_SEG;
            8'h27:                                      cls.group = xopd_pkg::GRP_DAA;
            [8'h28:8'h2D]:                              cls.group = xopd_pkg::GRP_SUB;
            8'h2F:                                      cls.group = xopd_pkg::GRP_DAS;
            [8'h30:8'h35]:                              cls.group = xopd_pkg::GRP_XOR;
            8'h37:                                      cls.group = xopd_pkg::GRP_AAA;
            [8'h38:8'h3D]:                              cls.group = xopd_pkg::GRP_CMP;
            8'h3F:                                      cls.group = xopd_pkg::GRP_AAS;
            [8'h40:8'h47]:                              cls.group = xopd_pkg::GRP_INC;
            [8'h48:8'h4F]:                              cls.group = xopd_pkg::GRP_DEC;
            [8'h70:8'h7F], [8'hE9:8'hEB]:               cls.group = xopd_pkg::GRP_JUMP;
            8'h80:                                      cls.group = xopd_pkg::GRP_IMM80;
            8'h81:                                      cls.group = xopd_pkg::GRP_IMM81;
            // 0x83 shares the 0x82 handler
            8'h82, 8'h83:                               cls.group = xopd_pkg::GRP_IMM82;
            [8'h84:8'h85], [8'hA8:8'hA9]:               cls.group = xopd_pkg::GRP_TEST;
            [8'h86:8'h87], [8'h91:8'h97]:               cls.group = xopd_pkg::GRP_XCHG;
            8'h90:                                      cls.group = xopd_pkg::GRP_NOP;
            [8'h88:8'h8C], 8'h8E, [8'hA0:8'hA3],
            [8'hB0:8'hBF], [8'hC6:8'hC7]:               cls.group = xopd_pkg::GRP_MOV;
            8'h8D:                                      cls.group = xopd_pkg::GRP_LEA;
            8'h98:                                      cls.group = xopd_pkg::GRP_CBW;
            8'h99:                                      cls.group = xopd_pkg::GRP_CWD;
            8'h9A, 8'hE8:                               cls.group = xopd_pkg::GRP_CALL;
            8'h9B:                                      cls.group = xopd_pkg::GRP_WAIT;
            8'h9E:                                      cls.group = xopd_pkg::GRP_SAHF;
            8'h9F:                                      cls.group = xopd_pkg::GRP_LAHF;
            [8'hA4:8'hA5]:                              cls.group = xopd_pkg::GRP_MOVS;
            [8'hA6:8'hA7]:                              cls.group = xopd_pkg::GRP_CMPS;
            [8'hAA:8'hAB]:                              cls.group = xopd_pkg::GRP_STOS;
            [8'hAC:8'hAD]:                              cls.group = xopd_pkg::GRP_LODS;
            [8'hAE:8'hAF]:                              cls.group = xopd_pkg::GRP_SCAS;
            [8'hC2:8'hC3], [8'hCA:8'hCB]:               cls.group = xopd_pkg::GRP_RET;
            8'hC4:                                      cls.group = xopd_pkg::GRP_LES;
            8'hC5:                                      cls.group = xopd_pkg::GRP_LDS;
            [8'hCC:8'hCD]:                              cls.group = xopd_pkg::GRP_INT;
            8'hCE:                                      cls.group = xopd_pkg::GRP_INTO;
            8'hCF:                                      cls.group = xopd_pkg::GRP_IRET;
            8'hD0:                                      cls.group = xopd_pkg::GRP_SHIFT_D0;
            8'hD1:                                      cls.group = xopd_pkg::GRP_SHIFT_D1;
            8'hD2:                                      cls.group = xopd_pkg::GRP_SHIFT_D2;
            8'hD3:                                      cls.group = xopd_pkg::GRP_SHIFT_D3;
            8'hD4:                                      cls.group = xopd_pkg::GRP_AAM;
            8'hD5:                                      cls.group = xopd_pkg::GRP_AAD;
            8'hD7:                                      cls.group = xopd_pkg::GRP_XLAT;
            // only the first escape code has a handler
            8'hD8:                                      cls.group = xopd_pkg::GRP_ESC;
            8'hE0:                                      cls.group = xopd_pkg::GRP_LOOPNE;
            8'hE1:                                      cls.group = xopd_pkg::GRP_LOOPE;
            8'hE2:                                      cls.group = xopd_pkg::GRP_LOOP;
            8'hE3:                                      cls.group = xopd_pkg::GRP_JCXZ;
            [8'hE4:8'hE5], [8'hEC:8'hED]:               cls.group = xopd_pkg::GRP_IN;
            [8'hE6:8'hE7], [8'hEE:8'hEF]:               cls.group = xopd_pkg::GRP_OUT;
            8'hF0:                                      cls.group = xopd_pkg::GRP_LOCK;
            8'hF2:                                      cls.group = xopd_pkg::GRP_REPNE;
            8'hF3:                                      cls.group = xopd_pkg::GRP_REP;
            8'hF4:                                      cls.group = xopd_pkg::GRP_HLT;
            8'hF5:                                      cls.group = xopd_pkg::GRP_CMC;
            8'hF6:                                      cls.group = xopd_pkg::GRP_UNARY_F6;
            8'hF7:                                      cls.group = xopd_pkg::GRP_UNARY_F7;
            8'hF8:                                      cls.group = xopd_pkg::GRP_CLC;
            8'hF9:                                      cls.group = xopd_pkg::GRP_STC;
            8'hFA:                                      cls.group = xopd_pkg::GRP_CLI;
            8'hFB:                                      cls.group = xopd_pkg::GRP_STI;
            8'hFC:                                      cls.group = xopd_pkg::GRP_CLD;
            8'hFD:                                      cls.group = xopd_pkg::GRP_STD;
            8'hFE:                                      cls.group = xopd_pkg::GRP_MISC_FE;
            8'hFF:                                      cls.group = xopd_pkg::GRP_MISC_FF;
            default:
            begin
                // unassigned opcode, group reads as zero
                cls.known = 1'b0;
                cls.group = xopd_pkg::GRP_ADD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/x86_primary_opcode_group_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86_primary_opcode_group_decode
// classifies an 8086 opcode byte into its handler group and splits the modrm byte
// ----------------------------------------------------------------------------
//
//  channel   role   word            contents
//  insn      sink   insn_word_t     opcode byte, modrm byte
//  result    source decode_word_t   valid flag, group, d/w bits, mod/reg/rm
//
//  two register stages: the instruction word is captured, decoded in one
//  short combinational pass, and the decoded word lands in the result register
//  one word per cycle sustained while result.ready holds
//  rst_n clears only the two stage valid flags, payload registers are not reset
//  a stalled result holds its register; the input stage keeps accepting as
//  long as the word ahead of it can move, so ready follows the output side
//
module x86_primary_opcode_group_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    xopd_insn_if.sink              insn,
    xopd_decode_if.source          result
);

    // input stage
    logic                       insn_valid_reg;
    xopd_pkg::insn_word_t       insn_reg;

    // result stage
    logic                       res_valid_reg;
    xopd_pkg::decode_word_t     res_reg;
    xopd_pkg::decode_word_t     res_next;

    logic                       res_ready;
    logic                       insn_ready;
    xopd_pkg::class_t           cls;

    // result register can load when empty or being drained this cycle
    assign res_ready  = !res_valid_reg || result.ready;
    // input register can load when empty or moving forward this cycle
    assign insn_ready = !insn_valid_reg || res_ready;

    assign insn.ready   = insn_ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    xopd_classify u_classify (
        .opcode (insn_reg.first_byte),
        .cls    (cls)
    );

    // field split of the captured word
    always_comb
    begin
        res_next.valid_res = cls.known;
        res_next.group     = cls.group;
        res_next.dir_bit   = insn_reg.first_byte[1];
        res_next.word_bit  = insn_reg.first_byte[0];
        res_next.mod_field = insn_reg.second_byte[7:6];
        res_next.reg_field = insn_reg.second_byte[5:3];
        res_next.rm_field  = insn_reg.second_byte[2:0];
    end

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insn_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (insn_ready)
            begin
                insn_valid_reg <= insn.valid;
            end
            if (res_ready)
            begin
                res_valid_reg <= insn_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (insn_ready && insn.valid)
        begin
            insn_reg <= insn.data;
        end
        if (res_ready && insn_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire
